// ===== sv/fce_pkg.sv =====
// Shared constants, status and mode codes, and controller/datapath structs
// for the chained-block file byte engine. No dependencies.
`default_nettype none
package fce_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int NUM_BLOCKS  = 64;
	localparam int MAX_OPEN    = 8;
	localparam int BLK_W   = 6;
	localparam int CHAIN_W = 7;
	localparam int POS_W   = 13;
	localparam int HND_W   = 3;
	localparam int OFS_W   = $clog2(BLOCK_BYTES);
	localparam int STEP_W  = POS_W - OFS_W;
	localparam int DISK_DEPTH = NUM_BLOCKS * BLOCK_BYTES;

	localparam logic [CHAIN_W-1:0] CHAIN_END = 7'd127;
	localparam logic [POS_W-1:0]   POS_MAX   = 13'h1FFF;
	localparam logic [BLK_W-1:0]   FDB_RESET = 6'd7;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NOFREE = 2'd2;
	localparam logic [1:0] ST_BROKEN = 2'd3;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	typedef struct packed {
		logic       latch;
		logic       load;
		logic       start;
		logic       step_rd;
		logic       advance;
		logic       scan_init;
		logic       scan_inc;
		logic       link_wr;
		logic       mark_wr;
		logic       disk_wr;
		logic       disk_rd;
		logic       disk_done;
		logic       set_code;
		logic [1:0] code;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic bad_handle;
		logic is_load;
		logic is_write;
		logic is_read;
		logic range_fail;
		logic first_bad;
		logic steps_zero;
		logic nxt_end;
		logic nxt_bad;
		logic scan_done;
		logic scan_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/fce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/fce_dp.sv =====
// Datapath: item latch, open-file table, chain table and disk RAMs, walk and
// free-scan registers, result word. Depends on fce_pkg and fce_ram.
`default_nettype none
module fce_dp import fce_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [BLK_W-1:0]   cfg_wdata,
	input  wire logic [1:0]         mode,
	input  wire logic [HND_W-1:0]   handle,
	input  wire logic [7:0]         data_in,
	input  wire logic               last_byte,
	input  wire logic [BLK_W-1:0]   load_first_block,
	input  wire logic [POS_W-1:0]   load_position,
	input  wire logic [POS_W-1:0]   load_length,
	input  wire cmd_t               cmd,
	output      sts_t               sts,
	output      logic [7:0]         data_out,
	output      logic [1:0]         status,
	output      logic [POS_W-1:0]   position_out
);
	logic [1:0]         mode_q;
	logic [HND_W-1:0]   h_q;
	logic [7:0]         data_q;
	logic               last_q;
	logic [BLK_W-1:0]   ld_blk_q;
	logic [POS_W-1:0]   ld_pos_q;
	logic [POS_W-1:0]   ld_len_q;

	logic [BLK_W-1:0]   fblk_q [MAX_OPEN];
	logic [POS_W-1:0]   fpos_q [MAX_OPEN];
	logic [POS_W-1:0]   flen_q [MAX_OPEN];
	logic [MAX_OPEN-1:0] fmod_q;
	logic [BLK_W-1:0]   fdb_q;

	logic [NUM_BLOCKS-1:0] cvld_q;
	logic                  cvld_rd_q;
	logic [BLK_W-1:0]      blk_q;
	logic [STEP_W-1:0]     steps_q;
	logic [CHAIN_W-1:0]    idx_q;
	logic [1:0]            code_q;
	logic [7:0]            rbyte_q;

	logic [CHAIN_W-1:0] c_rdata, c_wdata, nxt;
	logic [BLK_W-1:0]   c_waddr;
	logic [7:0]         d_rdata;
	logic [POS_W-1:0]   cur_pos, pos_inc;
	logic               h_ok;

	assign h_ok    = 32'(h_q) < MAX_OPEN;
	assign cur_pos = fpos_q[h_q];
	assign pos_inc = cur_pos + 1'b1;
	assign nxt     = cvld_rd_q ? c_rdata : '0;

	always_comb begin
		sts.bad_handle = !h_ok;
		sts.is_load    = mode_q == MODE_LOAD;
		sts.is_write   = mode_q == MODE_WRITE;
		sts.is_read    = mode_q == MODE_READ;
		sts.range_fail = (mode_q == MODE_WRITE) ? (cur_pos >= POS_MAX)
		                                        : (cur_pos >= flen_q[h_q]);
		sts.first_bad  = 32'(fblk_q[h_q]) >= NUM_BLOCKS;
		sts.steps_zero = steps_q == '0;
		sts.nxt_end    = nxt == CHAIN_END;
		sts.nxt_bad    = nxt == '0 || 32'(nxt) >= NUM_BLOCKS;
		sts.scan_done  = 32'(idx_q) >= NUM_BLOCKS || idx_q >= CHAIN_END;
		sts.scan_free  = !cvld_q[idx_q[BLK_W-1:0]];
	end

	// link writes the found block into the current entry, mark ends the chain there
	assign c_waddr = cmd.mark_wr ? idx_q[BLK_W-1:0] : blk_q;
	assign c_wdata = cmd.mark_wr ? CHAIN_END : idx_q;

	fce_ram #(.WIDTH(CHAIN_W), .DEPTH(NUM_BLOCKS)) u_chain (
		.clk   (clk),
		.we    (cmd.link_wr | cmd.mark_wr),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (cmd.step_rd),
		.raddr (blk_q),
		.rdata (c_rdata)
	);

	fce_ram #(.WIDTH(8), .DEPTH(DISK_DEPTH)) u_disk (
		.clk   (clk),
		.we    (cmd.disk_wr),
		.waddr ({blk_q, cur_pos[OFS_W-1:0]}),
		.wdata (data_q),
		.re    (cmd.disk_rd),
		.raddr ({blk_q, cur_pos[OFS_W-1:0]}),
		.rdata (d_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q   <= mode;
			h_q      <= handle;
			data_q   <= data_in;
			last_q   <= last_byte;
			ld_blk_q <= load_first_block;
			ld_pos_q <= load_position;
			ld_len_q <= load_length;
		end
		if (cmd.step_rd)
			cvld_rd_q <= cvld_q[blk_q];
		if (cmd.start) begin
			blk_q   <= fblk_q[h_q];
			steps_q <= cur_pos[POS_W-1:OFS_W];
		end else if (cmd.advance) begin
			blk_q   <= nxt[BLK_W-1:0];
			steps_q <= steps_q - 1'b1;
		end else if (cmd.mark_wr) begin
			blk_q   <= idx_q[BLK_W-1:0];
			steps_q <= steps_q - 1'b1;
		end
		if (cmd.scan_init)
			idx_q <= {1'b0, (fdb_q == '0) ? BLK_W'(1) : fdb_q};
		else if (cmd.scan_inc)
			idx_q <= idx_q + 1'b1;
		if (cmd.set_code)
			code_q <= cmd.code;
		if (cmd.disk_done)
			rbyte_q <= d_rdata;
		if (cmd.emit) begin
			data_out     <= (code_q == ST_OK && mode_q == MODE_READ) ? rbyte_q : 8'd0;
			status       <= code_q;
			position_out <= h_ok ? cur_pos : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdb_q  <= FDB_RESET;
			cvld_q <= '0;
			fmod_q <= '0;
			for (int i = 0; i < MAX_OPEN; i++) begin
				fblk_q[i] <= '0;
				fpos_q[i] <= '0;
				flen_q[i] <= '0;
			end
		end else begin
			if (cfg_we)
				fdb_q <= cfg_wdata;
			if (cmd.link_wr | cmd.mark_wr)
				cvld_q[c_waddr] <= 1'b1;
			if (cmd.load) begin
				fblk_q[h_q] <= ld_blk_q;
				fpos_q[h_q] <= ld_pos_q;
				flen_q[h_q] <= ld_len_q;
				fmod_q[h_q] <= 1'b0;
			end else if (cmd.disk_wr) begin
				fpos_q[h_q] <= pos_inc;
				if (pos_inc > flen_q[h_q])
					flen_q[h_q] <= pos_inc;
				if (last_q)
					fmod_q[h_q] <= 1'b1;
			end else if (cmd.disk_done) begin
				fpos_q[h_q] <= pos_inc;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/fce_ctrl.sv =====
// Controller: sequences dispatch, chain walk, free scan, linking and the disk
// access, and owns the word handshakes. Depends on fce_pkg.
`default_nettype none
module fce_ctrl import fce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output      logic in_ready,
	output      logic out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output      cmd_t cmd
);
	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_DISPATCH = 11'b00000000010,
		S_WALK     = 11'b00000000100,
		S_WALK_CHK = 11'b00000001000,
		S_SCAN     = 11'b00000010000,
		S_LINK     = 11'b00000100000,
		S_MARK     = 11'b00001000000,
		S_DISK_WR  = 11'b00010000000,
		S_DISK_RD  = 11'b00100000000,
		S_DISK_WT  = 11'b01000000000,
		S_FINISH   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   slot_free;

	assign in_ready  = state_q == S_IDLE;
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.set_code = 1'b1;
				state_d      = S_FINISH;
				priority if (sts.bad_handle)
					cmd.code = ST_RANGE;
				else if (sts.is_load) begin
					cmd.load = 1'b1;
					cmd.code = ST_OK;
				end else if (!sts.is_write && !sts.is_read)
					cmd.code = ST_OK;
				else if (sts.range_fail)
					cmd.code = ST_RANGE;
				else if (sts.first_bad)
					cmd.code = ST_BROKEN;
				else begin
					cmd.set_code = 1'b0;
					cmd.start    = 1'b1;
					state_d      = S_WALK;
				end
			end
			S_WALK: begin
				priority if (sts.steps_zero)
					state_d = sts.is_write ? S_DISK_WR : S_DISK_RD;
				else begin
					cmd.step_rd = 1'b1;
					state_d     = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				priority if (sts.nxt_end && sts.is_write) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (sts.nxt_end || sts.nxt_bad) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_BROKEN;
					state_d      = S_FINISH;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_WALK;
				end
			end
			S_SCAN: begin
				priority if (sts.scan_done) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_NOFREE;
					state_d      = S_FINISH;
				end else if (sts.scan_free)
					state_d = S_LINK;
				else
					cmd.scan_inc = 1'b1;
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				state_d     = S_MARK;
			end
			S_MARK: begin
				cmd.mark_wr = 1'b1;
				state_d     = S_WALK;
			end
			S_DISK_WR: begin
				cmd.disk_wr  = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code     = ST_OK;
				state_d      = S_FINISH;
			end
			S_DISK_RD: begin
				cmd.disk_rd = 1'b1;
				state_d     = S_DISK_WT;
			end
			S_DISK_WT: begin
				cmd.disk_done = 1'b1;
				cmd.set_code  = 1'b1;
				cmd.code      = ST_OK;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== sv/fat_chain_file_byte_engine_core.sv =====
// Top level of the chained-block file byte engine: controller plus datapath.
// Depends on fce_pkg, fce_ctrl, fce_dp (which holds two fce_ram instances).
//
// One word at a time. A load, or a word rejected at dispatch, goes from
// dispatch to the finish state, which registers its result. A write walks the
// chain, then writes the disk byte; a read walks it, then reads the disk RAM.
// The walk follows one chain link per 64 bytes of position (at most 127).
// Each block linked in needs a free-block scan of chain-table entries (up to
// 63), a link write and a mark write. A walk that finds a broken chain ends
// early. The chain table is a 64-entry RAM with one registered read port, read
// once per link. Its per-entry valid flags reset at once, so no clearing pass
// is needed. Disk bytes sit in a 4096-byte RAM. The result register lets a new
// word be accepted while the previous result is pending.
`default_nettype none
module fat_chain_file_byte_engine_core import fce_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [BLK_W-1:0]   cfg_wdata,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic [HND_W-1:0]   handle,
	input  wire logic [7:0]         data_in,
	input  wire logic               last_byte,
	input  wire logic [BLK_W-1:0]   load_first_block,
	input  wire logic [POS_W-1:0]   load_position,
	input  wire logic [POS_W-1:0]   load_length,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [7:0]         data_out,
	output      logic [1:0]         status,
	output      logic [POS_W-1:0]   position_out
);
	cmd_t cmd;
	sts_t sts;

	fce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fce_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.mode             (mode),
		.handle           (handle),
		.data_in          (data_in),
		.last_byte        (last_byte),
		.load_first_block (load_first_block),
		.load_position    (load_position),
		.load_length      (load_length),
		.cmd              (cmd),
		.sts              (sts),
		.data_out         (data_out),
		.status           (status),
		.position_out     (position_out)
	);
endmodule
`default_nettype wire
